>>> rtl/spq_pkg.sv
package spq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_EXTRACTED = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;

  localparam int TAG_W    = 32;
  localparam int RANK_W   = 3;
  localparam int OCC_W    = 5;
  localparam int STATUS_W = 3;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic            load;
    logic            insert;
    logic            pop;
    logic            clear;
    logic            emit;
    logic [2:0]      code;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       empty;
    logic       full;
  } dp_stat_t;

endpackage

>>> rtl/spq_ctrl.sv
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::dp_stat_t stat,
  output spq_pkg::ctl_cmd_t cmd
);

  spq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != spq_pkg::S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.code   = spq_pkg::ST_INSERTED;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = spq_pkg::S_EXEC;
        end
      end
      spq_pkg::S_EXEC: begin
        cmd.emit  = 1'b1;
        state_nxt = spq_pkg::S_IDLE;
        case (spq_pkg::opcode_t'(stat.opcode))
          spq_pkg::OP_INSERT: begin
            if (stat.full) begin
              cmd.code = spq_pkg::ST_FULL;
            end else begin
              cmd.insert = 1'b1;
              cmd.code   = spq_pkg::ST_INSERTED;
            end
          end
          spq_pkg::OP_EXTRACT: begin
            if (stat.empty) begin
              cmd.code = spq_pkg::ST_EMPTY;
            end else begin
              cmd.pop  = 1'b1;
              cmd.code = spq_pkg::ST_EXTRACTED;
            end
          end
          spq_pkg::OP_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.code  = spq_pkg::ST_CLEARED;
          end
          default: begin
            cmd.code = spq_pkg::ST_INSERTED;
          end
        endcase
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/spq_dpath.sv
module spq_dpath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    in_opcode,
  input  logic [1:0]                    in_condition,
  input  logic [spq_pkg::TAG_W-1:0]     in_entry_tag,
  input  spq_pkg::ctl_cmd_t             cmd,
  output spq_pkg::dp_stat_t             stat,
  output logic                          out_valid,
  output logic [spq_pkg::STATUS_W-1:0]  out_status,
  output logic [spq_pkg::TAG_W-1:0]     out_tag,
  output logic [spq_pkg::RANK_W-1:0]    out_rank,
  output logic [spq_pkg::OCC_W-1:0]     out_occupancy
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int OW = (CW > spq_pkg::OCC_W) ? CW : spq_pkg::OCC_W;

  logic [1:0]                  op_r;
  logic [spq_pkg::RANK_W-1:0]  rank_r;
  logic [spq_pkg::TAG_W-1:0]   tag_r;

  logic [spq_pkg::TAG_W-1:0]   slot_tag_r  [QUEUE_DEPTH];
  logic [spq_pkg::RANK_W-1:0]  slot_rank_r [QUEUE_DEPTH];
  logic [CW-1:0]               count_r, count_nxt;

  logic [QUEUE_DEPTH-1:0]      stay;
  logic [OW-1:0]               occ_wide;

  logic                        valid_r;
  logic [spq_pkg::STATUS_W-1:0] status_r;
  logic [spq_pkg::TAG_W-1:0]   otag_r;
  logic [spq_pkg::RANK_W-1:0]  orank_r;
  logic [spq_pkg::OCC_W-1:0]   occ_r;

  // request holding
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      rank_r <= spq_pkg::RANK_W'(in_condition) + spq_pkg::RANK_W'(1);
      tag_r  <= in_entry_tag;
    end
  end

  assign stat.opcode = op_r;
  assign stat.empty  = (count_r == '0);
  assign stat.full   = (count_r == CW'(QUEUE_DEPTH));

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.insert) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // held entries of equal or more urgent rank stay put on insert
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    assign stay[i] = (CW'(i) < count_r) && (slot_rank_r[i] <= rank_r);

    always_ff @(posedge clk) begin
      if (cmd.insert && !stay[i]) begin
        if (i == 0) begin
          slot_tag_r[i]  <= tag_r;
          slot_rank_r[i] <= rank_r;
        end else if (stay[(i == 0) ? 0 : i-1]) begin
          slot_tag_r[i]  <= tag_r;
          slot_rank_r[i] <= rank_r;
        end else begin
          slot_tag_r[i]  <= slot_tag_r[(i == 0) ? 0 : i-1];
          slot_rank_r[i] <= slot_rank_r[(i == 0) ? 0 : i-1];
        end
      end else if (cmd.pop && (i < QUEUE_DEPTH - 1)) begin
        // advance towards the head
        slot_tag_r[i]  <= slot_tag_r[(i < QUEUE_DEPTH - 1) ? i+1 : i];
        slot_rank_r[i] <= slot_rank_r[(i < QUEUE_DEPTH - 1) ? i+1 : i];
      end
    end
  end

  assign occ_wide = OW'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status_r <= cmd.code;
      otag_r   <= cmd.pop ? slot_tag_r[0]  : '0;
      orank_r  <= cmd.pop ? slot_rank_r[0] : '0;
      occ_r    <= occ_wide[spq_pkg::OCC_W-1:0];
    end
  end

  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_tag       = otag_r;
  assign out_rank      = orank_r;
  assign out_occupancy = occ_r;

endmodule

>>> rtl/stable_priority_queue_top.sv
// A request is held in the request registers, then worked in the EXEC state, and
// its result is registered onto the outputs. busy is high in the EXEC state, the
// compare-and-shift step over the sorted slot array, so no new request is taken.
// Results show for one cycle under out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
module stable_priority_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic [1:0]                    in_condition,
  input  logic [spq_pkg::TAG_W-1:0]     in_entry_tag,
  output logic                          out_valid,
  output logic [spq_pkg::STATUS_W-1:0]  out_status,
  output logic [spq_pkg::TAG_W-1:0]     out_tag,
  output logic [spq_pkg::RANK_W-1:0]    out_rank,
  output logic [spq_pkg::OCC_W-1:0]     out_occupancy
);

  spq_pkg::ctl_cmd_t cmd;
  spq_pkg::dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  spq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_opcode     (in_opcode),
    .in_condition  (in_condition),
    .in_entry_tag  (in_entry_tag),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_tag       (out_tag),
    .out_rank      (out_rank),
    .out_occupancy (out_occupancy)
  );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQUESTS = 400;
  localparam int CALM_TAIL = 40;

  typedef struct {
    opcode_t              op;
    logic [1:0]           condition;
    logic [TAG_W-1:0]     tag;
    logic                 settle_first;
  } queue_request_t;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [TAG_W-1:0]     tag;
    logic [RANK_W-1:0]    rank;
    logic [OCC_W-1:0]     occupancy;
  } queue_outcome_t;

  typedef struct {
    logic [TAG_W-1:0]     tag;
    logic [RANK_W-1:0]    rank;
  } held_entry_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_opcode = 2'd0;
  logic [1:0]           in_condition = 2'd0;
  logic [TAG_W-1:0]     in_entry_tag = '0;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [TAG_W-1:0]     out_tag;
  logic [RANK_W-1:0]    out_rank;
  logic [OCC_W-1:0]     out_occupancy;

  queue_request_t queued_requests[$];
  queue_request_t active_request;
  queue_outcome_t pending_outcomes[$];
  held_entry_t    model_entries[$];
  logic           request_taken = 1'b0;
  int             gap_left = 0;
  int             mismatch_count = 0;
  int             cycle_count = 0;

  stable_priority_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_opcode(in_opcode),
    .in_condition(in_condition),
    .in_entry_tag(in_entry_tag),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_tag(out_tag),
    .out_rank(out_rank),
    .out_occupancy(out_occupancy)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic add_request(input opcode_t op, input logic [1:0] condition,
                             input logic [TAG_W-1:0] tag, input logic settle = 1'b0);
    queue_request_t req;
    req.op = op;
    req.condition = condition;
    req.tag = tag;
    req.settle_first = settle;
    queued_requests.push_back(req);
  endtask

  // Predicts each result; an insert sorts behind every entry of equal or more urgent rank.
  function automatic queue_outcome_t predict_outcome(input queue_request_t req);
    queue_outcome_t res;
    held_entry_t    ent;
    int             pos;
    res.status = ST_INSERTED;
    res.tag = '0;
    res.rank = '0;
    case (req.op)
      OP_INSERT: begin
        if (model_entries.size() >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          ent.tag = req.tag;
          ent.rank = {1'b0, req.condition} + 3'd1;
          pos = 0;
          while (pos < model_entries.size() && model_entries[pos].rank <= ent.rank) pos++;
          model_entries.insert(pos, ent);
        end
      end
      OP_EXTRACT: begin
        if (model_entries.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          ent = model_entries.pop_front();
          res.status = ST_EXTRACTED;
          res.tag = ent.tag;
          res.rank = ent.rank;
        end
      end
      OP_CLEAR: begin
        model_entries.delete();
        res.status = ST_CLEARED;
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(model_entries.size());
    return res;
  endfunction

  // Check results first, then record the request taken at this edge.
  always @(posedge clk) begin : check_results
    queue_outcome_t want;
    if (!rst_n) begin
      request_taken <= 1'b0;
    end else begin
      if (out_valid !== 1'b0) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch($sformatf("result with none pending: status %0d tag %h",
                                    out_status, out_tag));
        end else begin
          want = pending_outcomes.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_tag !== want.tag)
            report_mismatch($sformatf("tag %h, want %h", out_tag, want.tag));
          if (out_rank !== want.rank)
            report_mismatch($sformatf("rank %0d, want %0d", out_rank, want.rank));
          if (out_occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, want %0d",
                                      out_occupancy, want.occupancy));
        end
      end
      request_taken <= start && !busy;
      if (start && !busy) pending_outcomes.push_back(predict_outcome(active_request));
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !request_taken) begin
      // hold the request until it is taken
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (queued_requests.size() == 0) begin
      start <= 1'b0;
    end else if (queued_requests[0].settle_first && pending_outcomes.size() != 0) begin
      start <= 1'b0;
    end else begin
      active_request = queued_requests.pop_front();
      in_opcode <= active_request.op;
      in_condition <= active_request.condition;
      in_entry_tag <= active_request.tag;
      start <= 1'b1;
      // no idle bursts near the end of the run
      if (queued_requests.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
        gap_left <= $urandom_range(1, 16);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stable_priority_queue_top regression: fail");
      $finish;
    end
  end

  initial begin
    opcode_t op;
    int      i;
    int      j;
    int      burst;
    int      kind;
    int      counted;
    logic    first;
    logic    settle;

    add_request(OP_EXTRACT, 2'd2, 32'h1234_5678);
    add_request(OP_NONE, 2'd3, 32'hFFFF_FFFF);
    add_request(OP_CLEAR, 2'd1, 32'h0000_0000);
    add_request(OP_INSERT, 2'd3, 32'hFFFF_FFFF);
    // more urgent entry must go ahead of the less urgent head
    add_request(OP_INSERT, 2'd0, 32'h0000_0000);
    add_request(OP_INSERT, 2'd1, 32'h5555_5555);
    // equal rank: behind the earlier extreme entry
    add_request(OP_INSERT, 2'd0, 32'h0000_0001);
    add_request(OP_INSERT, 2'd2, 32'hAAAA_AAAA);
    add_request(OP_NONE, 2'd0, 32'h0F0F_0F0F);
    for (i = 0; i < QUEUE_DEPTH - 5; i++)
      add_request(OP_INSERT, 2'(i % 4), 32'hC000_0000 | i);
    add_request(OP_INSERT, 2'd0, 32'hDEAD_BEEF);
    add_request(OP_EXTRACT, 2'd3, 32'hFFFF_FFFF);
    add_request(OP_CLEAR, 2'd0, 32'h8000_0000);

    // bursts of fills and drains so full and empty are both reached often
    counted = 0;
    first = 1'b1;
    while (counted < RANDOM_REQUESTS) begin
      kind = $urandom_range(0, 9);
      burst = (kind == 9) ? 1 : $urandom_range(1, 20);
      for (j = 0; j < burst; j++) begin
        if (kind < 3) begin
          op = OP_INSERT;
        end else if (kind < 6) begin
          op = OP_EXTRACT;
        end else if (kind < 9) begin
          i = $urandom_range(0, 19);
          op = (i < 9) ? OP_INSERT : (i < 17) ? OP_EXTRACT : (i < 18) ? OP_CLEAR : OP_NONE;
        end else begin
          op = ($urandom_range(0, 1) == 1) ? OP_CLEAR : OP_NONE;
        end
        settle = first || ($urandom_range(0, 39) == 0);
        add_request(op, 2'($urandom_range(0, 3)), $urandom, settle);
        first = 1'b0;
        if (op != OP_NONE) counted++;
      end
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    while (queued_requests.size() != 0 || start || pending_outcomes.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("stable_priority_queue_top regression: pass");
    end else begin
      $display("stable_priority_queue_top regression: fail");
    end
    $finish;
  end

endmodule
